/* rtl/core/sic_pkg.sv */
// ============================================================================
// sic_pkg
// Shared types and constants for the sorted ID intersection counter.
// ============================================================================
package sic_pkg;

    localparam int TYPES_DEFAULT    = 6;
    localparam int CAPACITY_DEFAULT = 1024;
    localparam int CMD_DEPTH        = 4;

    localparam int REQ_W   = 2;
    localparam int TYPE_W  = 3;
    localparam int ID_W    = 64;
    localparam int COUNT_W = 11;

    // Request codes on the input port
    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PROBE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_PROBE,
        OP_CLEAR
    } cmd_op_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [TYPE_W-1:0] particle_type;
        logic [ID_W-1:0]   particle_id;
        logic              last;
    } in_item_t;

    typedef struct packed {
        logic [TYPE_W-1:0]  result_type;
        logic [COUNT_W-1:0] common_count;
        logic               overflow;
    } out_item_t;

    // Classified command handed from the front to the back
    typedef struct packed {
        cmd_op_t           op;
        logic [TYPE_W-1:0] ptype;
        logic [ID_W-1:0]   id;
        logic              last;
    } cmd_t;

endpackage

/* rtl/core/sic_front.sv */
// ============================================================================
// sic_front
// Accepts request items, drops meaningless ones and registers the command.
// ============================================================================
module sic_front #(
    parameter int TYPES = sic_pkg::TYPES_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  sic_pkg::in_item_t request,
    output logic             cmd_valid,
    input  logic             cmd_full,
    output sic_pkg::cmd_t    cmd
);
    import sic_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    cmd_t  cmd_reg;
    cmd_t  cmd_next;
    logic  accept;
    logic  keep;
    logic  in_range;

    assign in_range  = {1'b0, request.particle_type} < (TYPE_W + 1)'(TYPES);
    assign full      = valid_reg && cmd_full;
    assign accept    = push && !full;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        keep             = 1'b0;
        cmd_next.op      = OP_LOAD;
        cmd_next.ptype   = request.particle_type;
        cmd_next.id      = request.particle_id;
        cmd_next.last    = request.last;
        unique case (request.req_type)
            REQ_LOAD:
            begin
                cmd_next.op = OP_LOAD;
                keep        = in_range;
            end
            REQ_PROBE:
            begin
                cmd_next.op = OP_PROBE;
                keep        = in_range;
            end
            REQ_CLEAR:
            begin
                cmd_next.op = OP_CLEAR;
                keep        = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = keep;
        end
        else if (valid_reg && !cmd_full)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

/* rtl/core/sic_fifo.sv */
// ============================================================================
// sic_fifo
// Short command queue between the front and the back.
// ============================================================================
module sic_fifo #(
    parameter int DEPTH = sic_pkg::CMD_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  sic_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output logic          rd_valid,
    output sic_pkg::cmd_t rd_data
);
    import sic_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_wr;
    logic              do_rd;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/core/sic_back.sv */
// ============================================================================
// sic_back
// ID memory, per-type fill/pointer/count state and the probe walk.
// ============================================================================
module sic_back #(
    parameter int TYPES    = sic_pkg::TYPES_DEFAULT,
    parameter int CAPACITY = sic_pkg::CAPACITY_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  sic_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    output logic               empty,
    input  logic               pop,
    output sic_pkg::out_item_t result
);
    import sic_pkg::*;

    localparam int TIW   = (TYPES > 1) ? $clog2(TYPES) : 1;
    localparam int PW    = $clog2(CAPACITY + 1);
    localparam int DEPTH = TYPES * CAPACITY;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_WAIT
    } state_t;

    logic [ID_W-1:0] mem [DEPTH];

    state_t          state_reg;
    state_t          state_next;
    logic [PW-1:0]   fill_reg [TYPES];
    logic [PW-1:0]   fill_next [TYPES];
    logic [PW-1:0]   ptr_reg [TYPES];
    logic [PW-1:0]   ptr_next [TYPES];
    logic [PW-1:0]   cnt_reg [TYPES];
    logic [PW-1:0]   cnt_next [TYPES];
    logic            overflow_reg;
    logic            overflow_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    out_item_t       out_data_reg;
    out_item_t       out_data_next;

    // Work registers of the probe in flight
    logic [TIW-1:0]  wt_reg;
    logic [TIW-1:0]  wt_next;
    logic [ID_W-1:0] wid_reg;
    logic [ID_W-1:0] wid_next;
    logic            wlast_reg;
    logic            wlast_next;
    logic [PW-1:0]   wp_reg;
    logic [PW-1:0]   wp_next;
    logic [PW-1:0]   wn_reg;
    logic [PW-1:0]   wn_next;
    logic [PW-1:0]   wcnt_reg;
    logic [PW-1:0]   wcnt_next;
    logic [AW-1:0]   waddr_reg;
    logic [AW-1:0]   waddr_next;
    logic [ID_W-1:0] rdata_reg;

    logic [TIW-1:0]  ti;
    logic [AW:0]     base;
    logic [AW:0]     start_addr;
    logic [AW:0]     load_addr;
    logic            slot_free;
    logic            id_lt;
    logic            id_eq;
    logic [PW-1:0]   wp_inc;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic            commit_try;
    logic [PW-1:0]   fin_p;
    logic [PW-1:0]   fin_cnt;

    assign ti         = cmd.ptype[TIW-1:0];
    assign base       = (AW + 1)'(ti) * (AW + 1)'(CAPACITY);
    assign start_addr = base + (AW + 1)'(ptr_reg[ti]);
    assign load_addr  = base + (AW + 1)'(fill_reg[ti]);
    assign slot_free  = !out_valid_reg || pop;
    assign id_lt      = rdata_reg < wid_reg;
    assign id_eq      = rdata_reg == wid_reg;
    assign wp_inc     = wp_reg + 1'b1;
    assign empty      = !out_valid_reg;
    assign result     = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        overflow_next  = overflow_reg;
        out_valid_next = out_valid_reg && !pop;
        out_data_next  = out_data_reg;
        wt_next        = wt_reg;
        wid_next       = wid_reg;
        wlast_next     = wlast_reg;
        wp_next        = wp_reg;
        wn_next        = wn_reg;
        wcnt_next      = wcnt_reg;
        waddr_next     = waddr_reg;
        rd_en          = 1'b0;
        rd_addr        = waddr_reg + 1'b1;
        wr_en          = 1'b0;
        cmd_pop        = 1'b0;
        commit_try     = 1'b0;
        fin_p          = wp_reg;
        fin_cnt        = wcnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        OP_CLEAR:
                        begin
                            for (int t = 0; t < TYPES; t++)
                            begin
                                fill_next[t] = '0;
                                ptr_next[t]  = '0;
                                cnt_next[t]  = '0;
                            end
                            overflow_next = 1'b0;
                        end
                        OP_LOAD:
                        begin
                            if (fill_reg[ti] < PW'(CAPACITY))
                            begin
                                wr_en         = 1'b1;
                                fill_next[ti] = fill_reg[ti] + 1'b1;
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        OP_PROBE:
                        begin
                            wt_next    = ti;
                            wid_next   = cmd.id;
                            wlast_next = cmd.last;
                            wp_next    = ptr_reg[ti];
                            wn_next    = fill_reg[ti];
                            wcnt_next  = cnt_reg[ti];
                            waddr_next = start_addr[AW-1:0];
                            if (ptr_reg[ti] < fill_reg[ti])
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = start_addr[AW-1:0];
                                state_next = ST_CMP;
                            end
                            else
                            begin
                                state_next = ST_WAIT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CMP:
            begin
                if (id_lt && (wp_inc < wn_reg))
                begin
                    // advance past a smaller stored ID, read the next one
                    wp_next    = wp_inc;
                    waddr_next = waddr_reg + 1'b1;
                    rd_en      = 1'b1;
                end
                else
                begin
                    fin_p      = (id_lt || id_eq) ? wp_inc : wp_reg;
                    fin_cnt    = id_eq ? wcnt_reg + 1'b1 : wcnt_reg;
                    wp_next    = fin_p;
                    wcnt_next  = fin_cnt;
                    commit_try = 1'b1;
                end
            end
            ST_WAIT:
            begin
                commit_try = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (commit_try)
        begin
            if (!wlast_reg)
            begin
                ptr_next[wt_reg] = fin_p;
                cnt_next[wt_reg] = fin_cnt;
                state_next       = ST_IDLE;
            end
            else if (slot_free)
            begin
                // report and rewind
                ptr_next[wt_reg]           = '0;
                cnt_next[wt_reg]           = '0;
                out_valid_next             = 1'b1;
                out_data_next.result_type  = TYPE_W'(wt_reg);
                out_data_next.common_count = COUNT_W'(fin_cnt);
                out_data_next.overflow     = overflow_reg;
                state_next                 = ST_IDLE;
            end
            else
            begin
                state_next = ST_WAIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int t = 0; t < TYPES; t++)
            begin
                fill_reg[t] <= '0;
                ptr_reg[t]  <= '0;
                cnt_reg[t]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
            fill_reg      <= fill_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        wt_reg       <= wt_next;
        wid_reg      <= wid_next;
        wlast_reg    <= wlast_next;
        wp_reg       <= wp_next;
        wn_reg       <= wn_next;
        wcnt_reg     <= wcnt_next;
        waddr_reg    <= waddr_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[load_addr[AW-1:0]] <= cmd.id;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/sorted_id_intersection_count_core.sv */
// ============================================================================
// sorted_id_intersection_count_core
// Per-type count of IDs shared by a stored sorted list and a probed sorted list.
// ============================================================================
// Probe: walks past each smaller stored ID of its type, one memory read per cycle;
//   a last probe waits for a free result slot before it reports.
// Commands: the back takes no new command while a probe is in flight.
// Reset: clears lists, pointers, counts, overflow flag and queues; the ID memory
//   is not cleared, only entries below each fill count are ever read.
module sorted_id_intersection_count_core #(
    parameter int TYPES    = sic_pkg::TYPES_DEFAULT,
    parameter int CAPACITY = sic_pkg::CAPACITY_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  sic_pkg::in_item_t  request,
    output logic               empty,
    input  logic               pop,
    output sic_pkg::out_item_t result
);
    import sic_pkg::*;

    logic front_valid;
    logic fifo_full;
    cmd_t front_cmd;
    logic back_pop;
    logic back_valid;
    cmd_t back_cmd;

    sic_front #(
        .TYPES (TYPES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .request   (request),
        .cmd_valid (front_valid),
        .cmd_full  (fifo_full),
        .cmd       (front_cmd)
    );

    sic_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (front_valid),
        .wr_data  (front_cmd),
        .full     (fifo_full),
        .rd_en    (back_pop),
        .rd_valid (back_valid),
        .rd_data  (back_cmd)
    );

    sic_back #(
        .TYPES    (TYPES),
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd       (back_cmd),
        .cmd_pop   (back_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
